/* sv/drpu_pkg.sv */
package drpu_pkg;

  localparam int CORDIC_W = 33;
  localparam int PROD_W   = 66;

  localparam logic [1:0] CMD_DEPLOY = 2'd0;
  localparam logic [1:0] CMD_ORDERS = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [CORDIC_W-1:0] CORDIC_GAIN = 33'd652032874;
  // floor(p / 225) == (p * RECIP_225) >> 39 for any 32-bit p
  localparam logic [31:0] RECIP_225   = 32'd2443359173;
  localparam logic [7:0]  DIVISOR     = 8'd225;
  // floor(v / 225) == (v * RECIP_FINE) >> 20 for v below 4096
  localparam logic [12:0] RECIP_FINE  = 13'd4661;
  localparam logic [11:0] HALF_BIAS   = 12'd112;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_DIV,
    ST_REM,
    ST_QUOT,
    ST_ITER,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ADD
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } cordic_ctl_t;

  function automatic logic [31:0] atan_f(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000145;
      5'd22:   v = 32'h000000A2;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* sv/drpu_if.sv */
interface drpu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [31:0]        time_now;
  logic signed [31:0] x_in;
  logic signed [31:0] y_in;
  logic signed [31:0] z_in;
  logic [15:0]        heading_in;
  logic [15:0]        speed_in;
  logic               heading_valid;
  logic               speed_valid;

  modport source (
    output valid, cmd, time_now, x_in, y_in, z_in, heading_in, speed_in,
           heading_valid, speed_valid,
    input  ready
  );
  modport sink (
    input  valid, cmd, time_now, x_in, y_in, z_in, heading_in, speed_in,
           heading_valid, speed_valid,
    output ready
  );
endinterface

interface drpu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [31:0]        fix_time_out;
  logic               deployed;

  modport source (
    output valid, pos_x, pos_y, pos_z, fix_time_out, deployed,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, fix_time_out, deployed,
    output ready
  );
endinterface

/* sv/drpu_cordic.sv */
module drpu_cordic import drpu_pkg::*; (
  input  logic                       clk,
  input  cordic_ctl_t                ctl,
  input  logic [15:0]                heading,
  input  logic [4:0]                 idx,
  output logic signed [CORDIC_W-1:0] sin_o,
  output logic signed [CORDIC_W-1:0] cos_o
);

  logic signed [CORDIC_W-1:0] x_r, y_r, z_r;
  logic signed [CORDIC_W-1:0] x_nxt, y_nxt, z_nxt;
  logic                       flip_r, flip_nxt;

  logic signed [16:0]         a_raw, a_fold;
  logic signed [CORDIC_W-1:0] xs, ys, at;

  always_comb begin
    a_raw    = signed'({heading[15], heading});
    a_fold   = a_raw;
    flip_nxt = flip_r;
    xs       = x_r >>> idx;
    ys       = y_r >>> idx;
    at       = signed'({1'b0, atan_f(idx)});
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (ctl.load) begin
      flip_nxt = 1'b0;
      if (a_raw > 17'sd16384) begin
        a_fold   = a_raw - 17'sd32768;
        flip_nxt = 1'b1;
      end else if (a_raw < -17'sd16384) begin
        a_fold   = a_raw + 17'sd32768;
        flip_nxt = 1'b1;
      end
      x_nxt = signed'(CORDIC_GAIN);
      y_nxt = '0;
      z_nxt = signed'({a_fold, 16'h0000});
    end else if (ctl.step) begin
      if (!z_r[CORDIC_W-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

endmodule

/* sv/dead_reckoning_position_update.sv */
// Dead-reckoning position tracker for one vessel.
// in_ch carries one command item per valid/ready handshake: deploy, change
// orders or time tick. out_ch returns exactly one item per command: position
// (low 32 bits of the position registers), fix time and deployed flag after
// the command has taken effect.
// Deploy, change orders, an unknown command and a tick while not deployed
// complete at once: the result is valid the cycle after acceptance, so with
// the receiver ready such items can be taken every cycle.
// A tick on a deployed vessel runs a CORDIC rotation for the heading; the
// divide by 3600 runs alongside its start (elapsed*speed product, reciprocal
// multiply on the shared multiplier, remainder, quotient fix-up). Then the
// shared multiplier forms the x and y offsets in turn, and a final add
// follows. One item is in work at a time; in_ch.ready is low until the
// result is back.
// The result is held until out_ch.ready; while it waits no new item is taken,
// except in the cycle in which it is taken.
// Synchronous reset clears the position, fix time, heading, speed and
// deployed flag and leaves no result pending.
module dead_reckoning_position_update import drpu_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int POS_WIDTH    = 32
) (
  input logic        clk,
  input logic        rst_n,
  drpu_in_if.sink    in_ch,
  drpu_out_if.source out_ch
);

  localparam int EW = (POS_WIDTH > 34) ? POS_WIDTH : 34;

  state_t                 state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   deployed_r, deployed_nxt;
  logic [POS_WIDTH-1:0]   pos_x_r, pos_x_nxt;
  logic [POS_WIDTH-1:0]   pos_y_r, pos_y_nxt;
  logic [POS_WIDTH-1:0]   pos_z_r, pos_z_nxt;
  logic [31:0]            fix_time_r, fix_time_nxt;
  logic [15:0]            heading_r, heading_nxt;
  logic [15:0]            speed_r, speed_nxt;
  logic [15:0]            emag_r, emag_nxt;
  logic                   eneg_r, eneg_nxt;
  logic [31:0]            p_r, p_nxt;
  logic [7:0]             rem_r, rem_nxt;
  logic [28:0]            dq_r, dq_nxt;
  logic [4:0]             cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  logic                       in_fire;
  logic [31:0]                diff, ndiff;
  logic [31:0]                p;
  logic [24:0]                a_q;
  logic [32:0]                a_x, b_full;
  logic [11:0]                fine_in;
  logic [24:0]                fine_prod;
  logic [28:0]                q_full;
  logic signed [29:0]         dq, d_s;
  logic signed [CORDIC_W-1:0] sin_v, cos_v, mul_a, mul_b;
  logic signed [63:0]         rnd;
  logic signed [33:0]         delta;
  logic signed [EW-1:0]       dext, xe, ye, ze;
  logic [EW-1:0]              ox, oy, oz;
  cordic_ctl_t                cctl;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign cctl.load = in_fire;
  assign cctl.step = (state_r != ST_IDLE) && (cnt_r < 5'(CORDIC_STEPS));

  drpu_cordic u_cordic (
    .clk     (clk),
    .ctl     (cctl),
    .heading (heading_r),
    .idx     (cnt_r),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  assign diff  = in_ch.time_now - fix_time_r;
  assign ndiff = 32'd0 - diff;
  assign p     = {16'd0, emag_r} * {16'd0, speed_r};

  // (|e|*speed*256 + 1800) / 3600 == (16p + 112) / 225, p = 225a + b
  assign a_q       = prod_r[63:39];
  assign a_x       = {8'd0, a_q} * {25'd0, DIVISOR};
  assign b_full    = {1'b0, p_r} - a_x;
  assign fine_in   = {rem_r, 4'b0000} + HALF_BIAS;
  assign fine_prod = {13'd0, fine_in} * {12'd0, RECIP_FINE};
  assign q_full    = {a_q, 4'b0000} + {24'd0, fine_prod[24:20]};

  assign dq  = signed'({1'b0, dq_r});
  assign d_s = eneg_r ? -dq : dq;

  always_comb begin
    if (state_r == ST_DIV) begin
      mul_a = signed'({1'b0, p_r});
      mul_b = signed'({1'b0, RECIP_225});
    end else begin
      mul_a = CORDIC_W'(d_s);
      mul_b = (state_r == ST_MUL_X) ? sin_v : cos_v;
    end
  end

  // round half up, then drop the Q30 fraction
  assign rnd   = 64'(prod_r) + 64'sd536870912;
  assign delta = rnd[63:30];
  assign dext  = EW'(delta);

  assign xe = EW'(in_ch.x_in);
  assign ye = EW'(in_ch.y_in);
  assign ze = EW'(in_ch.z_in);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    deployed_nxt  = deployed_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    pos_z_nxt     = pos_z_r;
    fix_time_nxt  = fix_time_r;
    heading_nxt   = heading_r;
    speed_nxt     = speed_r;
    emag_nxt      = emag_r;
    eneg_nxt      = eneg_r;
    p_nxt         = p_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    if (cctl.step) begin
      cnt_nxt = cnt_r + 5'd1;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          case (in_ch.cmd)
            CMD_DEPLOY: begin
              pos_x_nxt    = xe[POS_WIDTH-1:0];
              pos_y_nxt    = ye[POS_WIDTH-1:0];
              pos_z_nxt    = ze[POS_WIDTH-1:0];
              fix_time_nxt = in_ch.time_now;
              heading_nxt  = in_ch.heading_in;
              speed_nxt    = in_ch.speed_in;
              deployed_nxt = 1'b1;
            end
            CMD_ORDERS: begin
              if (in_ch.heading_valid) begin
                heading_nxt = in_ch.heading_in;
              end
              if (in_ch.speed_valid) begin
                speed_nxt = in_ch.speed_in;
              end
            end
            CMD_TICK: begin
              if (deployed_r) begin
                out_valid_nxt = 1'b0;
                fix_time_nxt  = in_ch.time_now;
                eneg_nxt      = diff[31];
                if (signed'(diff) > 32'sd65535 || signed'(diff) < -32'sd65535) begin
                  emag_nxt = ELAPSED_MAX;
                end else begin
                  emag_nxt = diff[31] ? ndiff[15:0] : diff[15:0];
                end
                cnt_nxt   = '0;
                state_nxt = ST_PROD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PROD: begin
        p_nxt     = p;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = ST_REM;
      end
      ST_REM: begin
        rem_nxt   = b_full[7:0];
        state_nxt = ST_QUOT;
      end
      ST_QUOT: begin
        dq_nxt    = q_full;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        pos_x_nxt = pos_x_r + dext[POS_WIDTH-1:0];
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        pos_y_nxt     = pos_y_r + dext[POS_WIDTH-1:0];
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      deployed_r  <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
      fix_time_r  <= '0;
      heading_r   <= '0;
      speed_r     <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      deployed_r  <= deployed_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      pos_z_r     <= pos_z_nxt;
      fix_time_r  <= fix_time_nxt;
      heading_r   <= heading_nxt;
      speed_r     <= speed_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emag_r <= emag_nxt;
    eneg_r <= eneg_nxt;
    p_r    <= p_nxt;
    rem_r  <= rem_nxt;
    dq_r   <= dq_nxt;
    prod_r <= prod_nxt;
  end

  assign ox = EW'(pos_x_r);
  assign oy = EW'(pos_y_r);
  assign oz = EW'(pos_z_r);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pos_x        = ox[31:0];
  assign out_ch.pos_y        = oy[31:0];
  assign out_ch.pos_z        = oz[31:0];
  assign out_ch.fix_time_out = fix_time_r;
  assign out_ch.deployed     = deployed_r;

endmodule
